// ===== hdl/jetc_pkg.sv =====
// Shared constants, codes and control types of the Julia escape-time classifier.
`default_nettype none

package jetc_pkg;

    localparam int FRAC_BITS   = 28;
    localparam int Z_WIDTH     = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int PROD_WIDTH  = 2 * Z_WIDTH;

    // Escape radius 2: |z|^2 > 4 in the squared-product scale
    localparam logic [PROD_WIDTH-1:0] MAG_LIMIT = PROD_WIDTH'(1) << (2 * FRAC_BITS + 2);

    // Configuration register indexes
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_C_REAL   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_C_IMAG   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_ITER = 2'd2;

    localparam logic signed [Z_WIDTH-1:0] C_REAL_RESET   = -32'sd536870912;
    localparam logic signed [Z_WIDTH-1:0] C_IMAG_RESET   = '0;
    localparam logic [COUNT_WIDTH-1:0]    MAX_ITER_RESET = 16'd256;

    // floor(x / 10) == (x * RECIP10) >> RECIP10_SHIFT for every 16-bit x
    localparam logic [COUNT_WIDTH-1:0] RECIP10       = 16'hCCCD;
    localparam int                     RECIP10_SHIFT = 19;
    localparam int                     DIV_WIDTH     = 2 * COUNT_WIDTH - RECIP10_SHIFT;

    // Color band codes
    localparam int BAND_WIDTH = 3;
    localparam logic [BAND_WIDTH-1:0] BAND_INSIDE = 3'd0;
    localparam logic [BAND_WIDTH-1:0] BAND_ORANGE = 3'd1;
    localparam logic [BAND_WIDTH-1:0] BAND_RED    = 3'd2;
    localparam logic [BAND_WIDTH-1:0] BAND_BLUE   = 3'd3;
    localparam logic [BAND_WIDTH-1:0] BAND_YELLOW = 3'd4;
    localparam logic [BAND_WIDTH-1:0] BAND_GREEN  = 3'd5;
    localparam logic [BAND_WIDTH-1:0] BAND_CYAN   = 3'd6;

    typedef struct packed {
        logic load;    // latch a new start point, clear the count
        logic mul;     // register the three products of the current z
        logic step;    // write z^2 + c back and count one step
        logic finish;  // load the result register
    } jetc_cmd_t;

    typedef struct packed {
        logic stop;    // escaped or count at the limit
    } jetc_status_t;

endpackage

`default_nettype wire

// ===== hdl/jetc_if.sv =====
// Handshake interfaces for the point, result and configuration channels.
`default_nettype none

interface jetc_point_if import jetc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [Z_WIDTH-1:0]  start_real;
    logic signed [Z_WIDTH-1:0]  start_imag;

    modport source (output valid, output start_real, output start_imag, input ready);
    modport sink   (input valid, input start_real, input start_imag, output ready);
endinterface

interface jetc_result_if import jetc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [COUNT_WIDTH-1:0]  escape_count;
    logic [BAND_WIDTH-1:0]   color_band;

    modport source (output valid, output escape_count, output color_band, input ready);
    modport sink   (input valid, input escape_count, input color_band, output ready);
endinterface

interface jetc_cfg_if import jetc_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [CFG_INDEX_WIDTH-1:0]  index;
    logic [CFG_DATA_WIDTH-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/jetc_ctrl.sv =====
// Sequencer of the escape-time iteration and owner of the result valid flag.
`default_nettype none

module jetc_ctrl import jetc_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    input  wire jetc_status_t status,
    output jetc_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_MUL    = 4'b0010,
        S_EVAL   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (status.stop)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_FINISH:
            begin
                // hold until the result register is free or being emptied
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/jetc_datapath.sv =====
// Complex squaring datapath, configuration registers and color band logic.
`default_nettype none

module jetc_datapath import jetc_pkg::*; (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire jetc_cmd_t                   cmd,
    output jetc_status_t                     status,
    input  wire logic signed [Z_WIDTH-1:0]   start_real,
    input  wire logic signed [Z_WIDTH-1:0]   start_imag,
    input  wire logic                        cfg_write,
    input  wire logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]   cfg_data,
    output logic [COUNT_WIDTH-1:0]           escape_count,
    output logic [BAND_WIDTH-1:0]            color_band
);

    localparam logic signed [PROD_WIDTH-1:0] Z_MAX =
        (PROD_WIDTH'(signed'(1)) <<< (Z_WIDTH - 1)) - PROD_WIDTH'(signed'(1));
    localparam logic signed [PROD_WIDTH-1:0] Z_MIN =
        -(PROD_WIDTH'(signed'(1)) <<< (Z_WIDTH - 1));
    localparam logic [DIV_WIDTH-1:0] DIV10_RESET  = DIV_WIDTH'(MAX_ITER_RESET / 10);
    localparam logic [DIV_WIDTH-1:0] DIV100_RESET = DIV_WIDTH'(MAX_ITER_RESET / 100);

    function automatic logic signed [Z_WIDTH-1:0] sat_z(input logic signed [PROD_WIDTH-1:0] v);
        logic signed [Z_WIDTH-1:0] r;
        if (v > Z_MAX)
            r = Z_MAX[Z_WIDTH-1:0];
        else if (v < Z_MIN)
            r = Z_MIN[Z_WIDTH-1:0];
        else
            r = v[Z_WIDTH-1:0];
        return r;
    endfunction

    // configuration
    logic signed [Z_WIDTH-1:0]  c_real_reg, c_imag_reg;
    logic [COUNT_WIDTH-1:0]     max_iter_reg;

    // iteration state
    logic signed [Z_WIDTH-1:0]  z_real_reg, z_real_next;
    logic signed [Z_WIDTH-1:0]  z_imag_reg, z_imag_next;
    logic [COUNT_WIDTH-1:0]     iter_count_reg, iter_count_next;
    logic signed [PROD_WIDTH-1:0] xx_reg, yy_reg, xy_reg;

    // band thresholds, follow max_iter through two registered steps
    logic [DIV_WIDTH-1:0]       div10_reg, div10_next;
    logic [DIV_WIDTH-1:0]       div100_reg, div100_next;
    logic [2*COUNT_WIDTH-1:0]   div10_prod, div100_prod;

    logic [COUNT_WIDTH-1:0]     escape_count_reg;
    logic [BAND_WIDTH-1:0]      color_band_reg, color_band_next;

    logic [PROD_WIDTH-1:0]        mag;
    logic signed [PROD_WIDTH-1:0] re_sum, im_sum;

    assign mag = $unsigned(xx_reg) + $unsigned(yy_reg);
    assign status.stop = (mag > MAG_LIMIT) || (iter_count_reg >= max_iter_reg);

    // floor shifts of the products, then add c
    assign re_sum = ((xx_reg - yy_reg) >>> FRAC_BITS) + PROD_WIDTH'(c_real_reg);
    assign im_sum = (xy_reg >>> (FRAC_BITS - 1)) + PROD_WIDTH'(c_imag_reg);

    always_comb
    begin
        z_real_next     = z_real_reg;
        z_imag_next     = z_imag_reg;
        iter_count_next = iter_count_reg;
        if (cmd.load)
        begin
            z_real_next     = start_real;
            z_imag_next     = start_imag;
            iter_count_next = '0;
        end
        else if (cmd.step)
        begin
            z_real_next     = sat_z(re_sum);
            z_imag_next     = sat_z(im_sum);
            iter_count_next = iter_count_reg + 1'b1;
        end
    end

    assign div10_prod  = (2*COUNT_WIDTH)'(max_iter_reg) * (2*COUNT_WIDTH)'(RECIP10);
    assign div100_prod = (2*COUNT_WIDTH)'(div10_reg) * (2*COUNT_WIDTH)'(RECIP10);
    assign div10_next  = div10_prod[2*COUNT_WIDTH-1:RECIP10_SHIFT];
    assign div100_next = div100_prod[2*COUNT_WIDTH-1:RECIP10_SHIFT];

    always_comb
    begin
        priority if (iter_count_reg >= max_iter_reg)
            color_band_next = BAND_INSIDE;
        else if (iter_count_reg > (max_iter_reg >> 3))
            color_band_next = BAND_ORANGE;
        else if (iter_count_reg > COUNT_WIDTH'(div10_reg))
            color_band_next = BAND_RED;
        else if (iter_count_reg > COUNT_WIDTH'(div10_reg >> 1))
            color_band_next = BAND_BLUE;
        else if (iter_count_reg > COUNT_WIDTH'(div10_reg >> 2))
            color_band_next = BAND_YELLOW;
        else if (iter_count_reg > COUNT_WIDTH'(div100_reg))
            color_band_next = BAND_GREEN;
        else
            color_band_next = BAND_CYAN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_real_reg     <= C_REAL_RESET;
            c_imag_reg     <= C_IMAG_RESET;
            max_iter_reg   <= MAX_ITER_RESET;
            z_real_reg     <= '0;
            z_imag_reg     <= '0;
            iter_count_reg <= '0;
            div10_reg      <= DIV10_RESET;
            div100_reg     <= DIV100_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_C_REAL:   c_real_reg   <= cfg_data[Z_WIDTH-1:0];
                    CFG_C_IMAG:   c_imag_reg   <= cfg_data[Z_WIDTH-1:0];
                    CFG_MAX_ITER: max_iter_reg <= cfg_data[COUNT_WIDTH-1:0];
                    default:      ;
                endcase
            end
            z_real_reg     <= z_real_next;
            z_imag_reg     <= z_imag_next;
            iter_count_reg <= iter_count_next;
            div10_reg      <= div10_next;
            div100_reg     <= div100_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            xx_reg <= PROD_WIDTH'(z_real_reg) * PROD_WIDTH'(z_real_reg);
            yy_reg <= PROD_WIDTH'(z_imag_reg) * PROD_WIDTH'(z_imag_reg);
            xy_reg <= PROD_WIDTH'(z_real_reg) * PROD_WIDTH'(z_imag_reg);
        end
        if (cmd.finish)
        begin
            escape_count_reg <= iter_count_reg;
            color_band_reg   <= color_band_next;
        end
    end

    assign escape_count = escape_count_reg;
    assign color_band   = color_band_reg;

endmodule

`default_nettype wire

// ===== hdl/julia_escape_time_classifier.sv =====
// Top level of the Julia escape-time classifier.
`default_nettype none

// Julia escape-time classifier. Each item on the point channel is a start
// point z0 in signed Q4.28; the block repeats z = z^2 + c while |z|^2 <= 4
// and the count is below max_iter, then returns one item on the result
// channel with the step count and a color band (0 inside the set, 1..6 by
// comparing the count with max_iter/8, /10, /20, /40 and /100). Components
// of z that leave the 32-bit range saturate. One point is worked on at a
// time: the block takes no new point until the last one has gone through
// the single complex-squaring loop, which registers x*x, y*y and x*y in
// the multiply state and writes z back from them in the evaluate state.
// The result waits in an output register, so the next point is taken
// while it is still unread. Write c_real, c_imag and max_iter only while
// the block is idle; the configuration channel is always ready and
// ignores unknown indexes.

module julia_escape_time_classifier import jetc_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    jetc_point_if.sink    point,
    jetc_result_if.source result,
    jetc_cfg_if.sink      cfg
);

    jetc_cmd_t    cmd;
    jetc_status_t status;
    logic         cfg_write;

    // configuration writes never stall
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    jetc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point.valid),
        .in_ready  (point.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    jetc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .start_real   (point.start_real),
        .start_imag   (point.start_imag),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .escape_count (result.escape_count),
        .color_band   (result.color_band)
    );

endmodule

`default_nettype wire

// ===== hdl/jetc_checker.sv =====
// Port-level assertions for the Julia escape-time classifier, with its bind.
`default_nettype none

module jetc_checker import jetc_pkg::*; (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        point_valid,
    input wire logic                        point_ready,
    input wire logic                        result_valid,
    input wire logic                        result_ready,
    input wire logic [COUNT_WIDTH-1:0]      escape_count,
    input wire logic [BAND_WIDTH-1:0]       color_band,
    input wire logic                        cfg_valid,
    input wire logic                        cfg_ready,
    input wire logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input wire logic [CFG_DATA_WIDTH-1:0]   cfg_data
);

    // track the iteration limit as written through the port
    logic [COUNT_WIDTH-1:0] max_iter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_iter_reg <= MAX_ITER_RESET;
        else if (cfg_valid && cfg_ready && (cfg_index == CFG_MAX_ITER))
            max_iter_reg <= cfg_data[COUNT_WIDTH-1:0];
    end

    // a stalled result holds its fields
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(escape_count) && $stable(color_band))
        else $error("stalled result changed");

    // one point at a time: the block busies itself after taking a point
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_ready |=> !point_ready)
        else $error("point accepted while another is in work");

    // the count never passes the limit and the band code is defined
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (escape_count <= max_iter_reg) && (color_band <= BAND_CYAN))
        else $error("escape count or band out of range");

    // inside band exactly when the limit was reached
    a_inside_band: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((color_band == BAND_INSIDE) == (escape_count >= max_iter_reg)))
        else $error("inside band disagrees with escape count");

endmodule

bind julia_escape_time_classifier jetc_checker u_jetc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_valid  (point.valid),
    .point_ready  (point.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .escape_count (result.escape_count),
    .color_band   (result.color_band),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data)
);

`default_nettype wire
